FILE: hdl/seeprom_pkg.sv
package seeprom_pkg;

    // store geometry
    localparam int ADDR_BITS = 10;
    localparam int STORE_WORDS = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] STORE_MASK = '1;
    localparam logic [15:0] ERASED_WORD = 16'hFFFF;

    // opcode field codes
    localparam logic [1:0] OP_EXT = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_ERASE = 2'd3;

    // sub-commands under the extended opcode
    localparam logic [1:0] SUB_WDS = 2'd0;
    localparam logic [1:0] SUB_WRAL = 2'd1;
    localparam logic [1:0] SUB_ERAL = 2'd2;
    localparam logic [1:0] SUB_EWEN = 2'd3;

    typedef enum logic [2:0] {
        K_NOP,
        K_WDS,
        K_WRAL,
        K_ERAL,
        K_EWEN,
        K_WRITE,
        K_READ,
        K_ERASE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] last;
    } decode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } state_t;

endpackage

FILE: hdl/seeprom_ram.sv
module seeprom_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/seeprom_decode.sv
module seeprom_decode
    import seeprom_pkg::*;
(
    input  logic        present,
    input  logic [15:0] command_word,
    output decode_t     dec
);

    logic [3:0]  top;
    logic [3:0]  abits;
    logic [15:0] fmask;
    logic [15:0] field;
    logic [1:0]  op;
    logic [1:0]  sub;

    // start bit position: highest set bit
    always_comb
    begin
        top = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (command_word[i])
            begin
                top = 4'(i);
            end
        end
    end

    // split into opcode, address field and sub-command
    always_comb
    begin
        abits = top - 4'd2;
        fmask = 16'((17'd1 << abits) - 17'd1);
        field = command_word & fmask;
        op = 2'(command_word >> abits);
        sub = 2'(field >> (abits - 4'd2));
    end

    // command classification
    always_comb
    begin
        dec.addr = field[ADDR_BITS-1:0];
        if (abits >= 4'(ADDR_BITS))
        begin
            dec.last = STORE_MASK;
        end
        else
        begin
            dec.last = fmask[ADDR_BITS-1:0];
        end

        if (!present || command_word == 16'd0)
        begin
            dec.kind = K_NOP;
        end
        else if (top < 4'd4)
        begin
            // no room for an address field
            dec.kind = K_WDS;
        end
        else
        begin
            unique case (op)
                OP_EXT:
                begin
                    unique case (sub)
                        SUB_WDS:  dec.kind = K_WDS;
                        SUB_WRAL: dec.kind = K_WRAL;
                        SUB_ERAL: dec.kind = K_ERAL;
                        SUB_EWEN: dec.kind = K_EWEN;
                    endcase
                end
                OP_WRITE: dec.kind = K_WRITE;
                OP_READ:  dec.kind = K_READ;
                OP_ERASE: dec.kind = K_ERASE;
            endcase
        end
    end

endmodule

FILE: hdl/serial_eeprom_command_unit_core.sv
// channel   | ports                                  | transfer when
// ----------+----------------------------------------+--------------------------
// command   | start, busy, command_word, write_data  | start high, busy low
// result    | done, read_data, writes_enabled        | done high (one cycle)
// config    | cfg_we, cfg_wdata                      | cfg_we high
//
// write, erase, enable/disable and no-op: result in the cycle after the transfer
// read: result through the registered memory read port, then the result registers
// write-all: sweep from address 0 to the last address; erase-all (writes enabled):
// the whole store, one memory word written per cycle by the sweep counter
// after reset a clearing pass over all STORE_WORDS (1024) words holds busy high
// the receiver cannot stall; each result is shown for exactly one cycle
module serial_eeprom_command_unit_core
    import seeprom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] command_word,
    input  logic [15:0] write_data,
    output logic        done,
    output logic [15:0] read_data,
    output logic        writes_enabled,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0] last_reg, last_next;
    logic [15:0]          fill_reg, fill_next;
    logic                 we_reg, we_next;
    logic                 present_reg;
    logic                 done_reg, done_next;
    logic [15:0]          read_data_reg, read_data_next;

    decode_t              dec;
    logic                 accept;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [15:0]          ram_wdata;
    logic [15:0]          ram_rdata;

    seeprom_decode u_decode (
        .present      (present_reg),
        .command_word (command_word),
        .dec          (dec)
    );

    seeprom_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (dec.addr),
        .rdata (ram_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign read_data = read_data_reg;
    assign writes_enabled = we_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == STORE_MASK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (dec.kind == K_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (dec.kind == K_WRAL || (dec.kind == K_ERAL && we_reg))
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory port control
    always_comb
    begin
        cnt_next = cnt_reg;
        last_next = last_reg;
        fill_next = fill_reg;
        we_next = we_reg;
        done_next = 1'b0;
        read_data_next = 16'd0;
        ram_we = 1'b0;
        ram_waddr = dec.addr;
        ram_wdata = write_data;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = ERASED_WORD;
                cnt_next = cnt_reg + ADDR_BITS'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (dec.kind)
                        K_NOP: ;
                        K_WDS: we_next = 1'b0;
                        K_EWEN: we_next = 1'b1;
                        K_WRITE:
                        begin
                            ram_we = we_reg;
                        end
                        K_ERASE:
                        begin
                            ram_we = we_reg;
                            ram_wdata = ERASED_WORD;
                        end
                        K_READ:
                        begin
                            done_next = 1'b0;
                        end
                        K_WRAL:
                        begin
                            done_next = 1'b0;
                            cnt_next = '0;
                            last_next = dec.last;
                            fill_next = write_data;
                        end
                        K_ERAL:
                        begin
                            if (we_reg)
                            begin
                                done_next = 1'b0;
                                cnt_next = '0;
                                last_next = STORE_MASK;
                                fill_next = ERASED_WORD;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next = 1'b1;
                read_data_next = ram_rdata;
            end
            ST_SWEEP:
            begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = fill_reg;
                cnt_next = cnt_reg + ADDR_BITS'(1);
                if (cnt_reg == last_reg)
                begin
                    done_next = 1'b1;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            we_reg <= 1'b0;
            present_reg <= 1'b1;
            done_reg <= 1'b0;
            read_data_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            we_reg <= we_next;
            done_reg <= done_next;
            read_data_reg <= read_data_next;
            if (cfg_we)
            begin
                present_reg <= cfg_wdata;
            end
        end
    end

    // sweep payload
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        fill_reg <= fill_next;
    end

    // a read transfer gives its result through the memory read register, then done_reg
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec.kind == K_READ) |-> ##2 done_reg)
        else $error("read result missing");

    // sweep counter never passes its end address
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (cnt_reg <= last_reg))
        else $error("sweep past end");

    // single-word writes only with the write enable latch set
    a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && ram_we) |-> we_reg)
        else $error("write without enable");

    // read data is zero outside a result cycle
    a_rdata_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (read_data_reg != 16'd0) |-> done_reg)
        else $error("read data outside result");

    // no memory write while a read is in flight
    a_read_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !ram_we)
        else $error("write during read");

endmodule
